### rtl/core/swtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared types and constants for the sorted watchpoint table.
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int EntryCount = 16;
    localparam int SlotCount  = 64;
    localparam int IdxW       = $clog2(EntryCount);
    localparam int CntW       = $clog2(EntryCount + 1);
    localparam int QDepth     = 2;

    typedef enum logic [1:0] {
        KIND_ENABLE  = 2'd0,
        KIND_DISABLE = 2'd1,
        KIND_LOOKUP  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_ALREADY     = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_NOT_ENABLED = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] address_mask;
        logic [15:0] range_length;
        logic [31:0] compare_value;
        logic [31:0] compare_mask;
        logic        compare_enable;
        logic [5:0]  slot;
    } entry_t;

    // classified request passed from front to back
    typedef struct packed {
        kind_t       kind;
        entry_t      entry;
        logic [31:0] access_address;
        logic [3:0]  access_length;
        logic [31:0] access_value;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       hit;
        logic [5:0] hit_slot;
        logic [4:0] enabled_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PROBE,
        S_DONE
    } state_t;

endpackage

### rtl/core/swtm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_req_if / swtm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface swtm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [31:0] entry_address;
    logic [31:0] entry_address_mask;
    logic [15:0] entry_range_length;
    logic [31:0] entry_compare_value;
    logic [31:0] entry_compare_mask;
    logic        entry_compare_enable;
    logic [31:0] access_address;
    logic [3:0]  access_length;
    logic [31:0] access_value;
    modport source (output valid, kind, slot, entry_address, entry_address_mask,
        entry_range_length, entry_compare_value, entry_compare_mask,
        entry_compare_enable, access_address, access_length, access_value,
        input ready);
    modport sink (input valid, kind, slot, entry_address, entry_address_mask,
        entry_range_length, entry_compare_value, entry_compare_mask,
        entry_compare_enable, access_address, access_length, access_value,
        output ready);
endinterface

interface swtm_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       hit;
    logic [5:0] hit_slot;
    logic [4:0] enabled_count;
    modport source (output valid, status, hit, hit_slot, enabled_count, input ready);
    modport sink (input valid, status, hit, hit_slot, enabled_count, output ready);
endinterface

### rtl/core/swtm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_front
// Accept requests and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module swtm_front
    import swtm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    swtm_req_if.sink      in,
    output logic          q_valid,
    output req_t          q_data,
    input  logic          q_pop
);

    req_t                        mem_reg [QDepth];
    logic [$clog2(QDepth)-1:0]   wr_reg, rd_reg;
    logic [$clog2(QDepth):0]     cnt_reg;
    logic                        push;
    req_t                        item;

    assign in.ready = (cnt_reg != QDepth[$clog2(QDepth):0]);
    assign push     = in.valid && in.ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_reg];

    always_comb
    begin
        item.kind                 = kind_t'(in.kind);
        item.entry.address        = in.entry_address;
        item.entry.address_mask   = in.entry_address_mask;
        item.entry.range_length   = in.entry_range_length;
        item.entry.compare_value  = in.entry_compare_value;
        item.entry.compare_mask   = in.entry_compare_mask;
        item.entry.compare_enable = in.entry_compare_enable;
        item.entry.slot           = in.slot;
        item.access_address       = in.access_address;
        item.access_length        = in.access_length;
        item.access_value         = in.access_value;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{$clog2(QDepth){1'b0}}, push}
                               - {{$clog2(QDepth){1'b0}}, q_pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == QDepth[$clog2(QDepth):0]) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");

endmodule

### rtl/core/swtm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_back
// Carry out enable, disable and lookup on the sorted entry table.
// ----------------------------------------------------------------------------
module swtm_back
    import swtm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sort_with_mask,
    input  logic          q_valid,
    input  req_t          q_data,
    output logic          q_pop,
    swtm_rsp_if.source    out
);

    entry_t               tab_reg [EntryCount];
    logic [CntW-1:0]      count_reg, count_next;
    state_t               state_reg, state_next;
    req_t                 req_reg;
    logic [CntW-1:0]      idx_reg, idx_next;
    logic [CntW-1:0]      pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [CntW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]          addr_reg, addr_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rvalid_reg, rvalid_next;
    logic [6:0]           last_hit_reg, last_hit_next;
    logic                 wr_en, sh_up, sh_dn;

    entry_t               cur;
    logic [IdxW-1:0]      mid;
    logic [CntW:0]        midsum;
    logic [31:0]          maddr;
    logic [33:0]          top;
    logic                 in_range, val_ok, after;

    function automatic logic [IdxW-1:0] mid_of(input logic [CntW-1:0] l,
                                               input logic [CntW-1:0] h);
        logic [CntW:0] s;
        begin
            s = {1'b0, l} + {1'b0, h};
            mid_of = s[IdxW:1];
        end
    endfunction

    function automatic logic [IdxW-1:0] mid_init(input logic [CntW-1:0] c);
        logic [CntW-1:0] h;
        begin
            h = c - 1'b1;
            mid_init = mid_of('0, h);
        end
    endfunction

    assign cur = tab_reg[idx_reg[IdxW-1:0]];
    assign q_pop = (state_reg == S_IDLE) && q_valid && !rvalid_reg;

    always_comb
    begin
        midsum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid    = midsum[IdxW:1];
    end

    // key compare for insertion scan
    always_comb
    begin
        if (cur.address != req_reg.entry.address)
        begin
            after = cur.address > req_reg.entry.address;
        end
        else if (sort_with_mask && cur.address_mask != req_reg.entry.address_mask)
        begin
            after = cur.address_mask > req_reg.entry.address_mask;
        end
        else
        begin
            after = cur.range_length > req_reg.entry.range_length;
        end
    end

    // probe test for lookup
    always_comb
    begin
        maddr    = addr_reg & cur.address_mask;
        top      = {2'b0, cur.address} + {18'b0, cur.range_length}
                   + {30'b0, req_reg.access_length};
        in_range = (maddr >= cur.address) && ({2'b0, maddr} < top);
        val_ok   = !cur.compare_enable ||
                   ((cur.compare_value & cur.compare_mask) ==
                    (req_reg.access_value & cur.compare_mask));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_data.kind)
                        KIND_ENABLE, KIND_DISABLE: state_next = S_SCAN;
                        KIND_LOOKUP:               state_next = S_PROBE;
                        default:                   state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                state_next = S_DONE;
            end
            S_PROBE:
            begin
                if (count_reg == '0 || lo_reg > hi_reg || in_range || lo_reg == hi_reg
                    || hi_reg[CntW-1])
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        addr_next     = addr_reg;
        rsp_next      = rsp_reg;
        rvalid_next   = rvalid_reg;
        count_next    = count_reg;
        last_hit_next = last_hit_reg;
        wr_en         = 1'b0;
        sh_up         = 1'b0;
        sh_dn         = 1'b0;
        if (rvalid_reg && out.ready)
        begin
            rvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                pos_next   = count_reg;
                found_next = 1'b0;
                lo_next    = '0;
                hi_next    = count_reg - 1'b1;
                addr_next  = q_data.access_address;
                // hold the waiting result until a new request is taken
                if (q_pop)
                begin
                    rsp_next = '0;
                end
            end
            S_SCAN:
            begin
                // one entry a cycle: find slot and insertion point
                if (idx_reg < count_reg)
                begin
                    if (cur.slot == req_reg.entry.slot && !found_reg)
                    begin
                        found_next = 1'b1;
                        if (req_reg.kind == KIND_DISABLE)
                        begin
                            pos_next = idx_reg;
                        end
                    end
                    if (req_reg.kind == KIND_ENABLE && after && pos_reg == count_reg)
                    begin
                        pos_next = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (req_reg.kind == KIND_ENABLE)
                begin
                    if (count_reg >= EntryCount[CntW-1:0])
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else if (found_reg)
                    begin
                        rsp_next.status = ST_ALREADY;
                    end
                    else
                    begin
                        sh_up      = 1'b1;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else if (!found_reg)
                    begin
                        rsp_next.status = ST_NOT_ENABLED;
                    end
                    else
                    begin
                        sh_dn      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_PROBE:
            begin
                if (!(count_reg == '0 || lo_reg > hi_reg || hi_reg[CntW-1])
                    && idx_reg == {1'b0, mid})
                begin
                    addr_next = maddr;
                    if (in_range)
                    begin
                        if (val_ok)
                        begin
                            rsp_next.hit      = 1'b1;
                            rsp_next.hit_slot = cur.slot;
                            last_hit_next     = {1'b1, cur.slot};
                        end
                    end
                    else if (cur.address > maddr)
                    begin
                        hi_next = {1'b0, mid} - 1'b1;
                    end
                    else
                    begin
                        lo_next = {1'b0, mid} + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                rsp_next.enabled_count = count_reg;
                rvalid_next            = 1'b1;
            end
            default: ;
        endcase
        // probe address follows the midpoint
        if (state_next == S_PROBE)
        begin
            idx_next = {1'b0, (state_reg == S_IDLE) ? mid_init(count_reg)
                                                     : mid_of(lo_next, hi_next)};
        end
    end

    // table storage: shift up for insert, down for remove
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < EntryCount; i++)
        begin
            if (sh_up && i[CntW-1:0] > pos_reg && i[CntW-1:0] <= count_reg)
            begin
                tab_reg[i] <= tab_reg[IdxW'(i - 1)];
            end
            else if (sh_dn && i[CntW-1:0] >= pos_reg && i < EntryCount - 1)
            begin
                tab_reg[i] <= tab_reg[IdxW'(i + 1)];
            end
            else if (wr_en && i[CntW-1:0] == pos_reg)
            begin
                tab_reg[i] <= req_reg.entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_data;
        end
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        addr_reg  <= addr_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rvalid_reg   <= 1'b0;
            last_hit_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rvalid_reg   <= rvalid_next;
            last_hit_reg <= last_hit_next;
        end
    end

    assign out.valid         = rvalid_reg;
    assign out.status        = rsp_reg.status;
    assign out.hit           = rsp_reg.hit;
    assign out.hit_slot      = rsp_reg.hit_slot;
    assign out.enabled_count = rsp_reg.enabled_count;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EntryCount[CntW-1:0]) else $error("count over capacity");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_SHIFT)
        else $error("count moved outside shift");
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && rsp_reg.hit) |-> rsp_reg.status == ST_OK)
        else $error("hit with error status");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !rvalid_reg) else $error("pop while result pending");

endmodule

### rtl/core/sorted_watchpoint_table_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_watchpoint_table_match
// Watchpoint unit with an address-sorted table and binary-search lookup.
// ----------------------------------------------------------------------------
// Enable/disable scan the table one entry a cycle, then shift it; lookup runs
//   a binary-search probe; an unused kind goes straight to its result.
// Throughput: one request at a time in the back end, and none taken before the
//   last result; the front queue holds two more and stalls the requester when full.
// Reset: asynchronous, active low; table empty, sort_with_mask cleared.
module sorted_watchpoint_table_match
    import swtm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    swtm_req_if.sink      req,
    swtm_rsp_if.source    rsp
);

    logic sort_with_mask_reg;
    logic q_valid, q_pop;
    req_t q_data;

    // hold the key-order select; the user writes it only while idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_with_mask_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            sort_with_mask_reg <= cfg_wdata;
        end
    end

    // front: accept requests into the queue
    swtm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (req),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // back: scan, shift and probe the table
    swtm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .sort_with_mask (sort_with_mask_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out            (rsp)
    );

endmodule

### sim/swtm_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_match_checker
// Watches the request and result channels of the watchpoint table, predicts
// every result from its own copy of the table and compares field by field.
// ----------------------------------------------------------------------------
module swtm_match_checker
    import swtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    swtm_req_if         req,
    swtm_rsp_if         rsp,
    output int          fail_count,
    output int          pending_count
);

    entry_t     wp_table [EntryCount];
    int         wp_count;
    logic       key_with_mask;
    rsp_t       expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int slot_position(logic [5:0] s);
        for (int i = 0; i < wp_count; i++)
        begin
            if (wp_table[i].slot == s)
                return i;
        end
        return -1;
    endfunction

    // true when stored entry e sorts strictly after the new entry
    function automatic bit sorts_after(entry_t e, entry_t n);
        if (e.address != n.address)
            return e.address > n.address;
        if (key_with_mask && e.address_mask != n.address_mask)
            return e.address_mask > n.address_mask;
        return e.range_length > n.range_length;
    endfunction

    function automatic int search_match(logic [31:0] addr, logic [3:0] len,
                                        logic [31:0] val);
        int lo;
        int hi;
        int mid;
        logic [33:0] upper;
        entry_t e;
        lo = 0;
        hi = wp_count - 1;
        while (wp_count > 0 && lo <= hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            e = wp_table[mid];
            // masks accumulate along the probe path
            addr &= e.address_mask;
            upper = {2'b0, e.address} + {18'b0, e.range_length} + {30'b0, len};
            if (addr >= e.address && {2'b0, addr} < upper)
            begin
                if (!e.compare_enable ||
                    (e.compare_value & e.compare_mask) == (val & e.compare_mask))
                    return mid;
                return -1;
            end
            if (lo == hi)
                return -1;
            if (e.address > addr)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    task automatic predict_request();
        rsp_t   r;
        entry_t n;
        int     pos;
        int     p;
        r = '0;
        n = '{address: req.entry_address, address_mask: req.entry_address_mask,
              range_length: req.entry_range_length,
              compare_value: req.entry_compare_value,
              compare_mask: req.entry_compare_mask,
              compare_enable: req.entry_compare_enable, slot: req.slot};
        case (kind_t'(req.kind))
            KIND_ENABLE:
            begin
                if (wp_count >= EntryCount)
                    r.status = ST_FULL;
                else if (slot_position(req.slot) >= 0)
                    r.status = ST_ALREADY;
                else
                begin
                    pos = 0;
                    while (pos < wp_count && !sorts_after(wp_table[pos], n))
                        pos++;
                    for (int i = wp_count; i > pos; i--)
                        wp_table[i] = wp_table[i - 1];
                    wp_table[pos] = n;
                    wp_count++;
                    r.status = ST_OK;
                end
            end
            KIND_DISABLE:
            begin
                p = slot_position(req.slot);
                if (wp_count == 0)
                    r.status = ST_EMPTY;
                else if (p < 0)
                    r.status = ST_NOT_ENABLED;
                else
                begin
                    for (int i = p; i + 1 < wp_count; i++)
                        wp_table[i] = wp_table[i + 1];
                    wp_count--;
                    r.status = ST_OK;
                end
            end
            KIND_LOOKUP:
            begin
                p = search_match(req.access_address, req.access_length,
                                 req.access_value);
                if (p >= 0)
                begin
                    r.hit = 1'b1;
                    r.hit_slot = wp_table[p].slot;
                end
            end
            default:
                r.status = ST_OK;
        endcase
        r.enabled_count = wp_count[4:0];
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            wp_count = 0;
            key_with_mask = 1'b0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                key_with_mask = cfg_wdata;
            if (req.valid && req.ready)
                predict_request();
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d hit %0b slot %0d count %0d",
                                 rsp.status, rsp.hit, rsp.hit_slot, rsp.enabled_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status || rsp.hit !== want.hit ||
                        rsp.hit_slot !== want.hit_slot ||
                        rsp.enabled_count !== want.enabled_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
                                     want.status, want.hit, want.hit_slot,
                                     want.enabled_count, rsp.status, rsp.hit,
                                     rsp.hit_slot, rsp.enabled_count);
                    end
                end
            end
        end
    end

endmodule

### sim/sorted_watchpoint_table_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_watchpoint_table_match_test
// Drives enable, disable and lookup requests into the watchpoint table with
// random gaps and result stalls, switches the sort key between phases and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module sorted_watchpoint_table_match_test;
    import swtm_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending_count;
    int   idle_cycles;
    bit   steady_mode;     // no random idling on either side
    bit   hold_off;        // receiver stops taking results

    // slots believed enabled, used to aim disables and addresses
    logic [5:0]  live_slots [$];
    logic [31:0] live_addrs [$];

    swtm_req_if req ();
    swtm_rsp_if rsp ();

    sorted_watchpoint_table_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    swtm_match_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off)
            rsp.ready <= 1'b0;
        else if (steady_mode)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(99) >= 36);
    end

    // watchdog: count cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= 5000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // present one request and hold it until accepted; valid stays high
    // after acceptance until the next request or an idle cycle drops it
    task automatic send_request(kind_t k, logic [5:0] s, logic [31:0] ea,
                                logic [31:0] em, logic [15:0] el,
                                logic [31:0] cv, logic [31:0] cm, logic ce,
                                logic [31:0] aa, logic [3:0] al,
                                logic [31:0] av);
        if (!steady_mode && $urandom_range(99) < 36)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
            while (!steady_mode && $urandom_range(99) < 36)
                @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= k;
        req.slot <= s;
        req.entry_address <= ea;
        req.entry_address_mask <= em;
        req.entry_range_length <= el;
        req.entry_compare_value <= cv;
        req.entry_compare_mask <= cm;
        req.entry_compare_enable <= ce;
        req.access_address <= aa;
        req.access_length <= al;
        req.access_value <= av;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic enable_entry(logic [5:0] s, logic [31:0] ea, logic [31:0] em,
                                logic [15:0] el, logic [31:0] cv,
                                logic [31:0] cm, logic ce);
        send_request(KIND_ENABLE, s, ea, em, el, cv, cm, ce,
                     $urandom, 4'($urandom), $urandom);
        if (live_slots.size() < EntryCount)
        begin
            live_slots.push_back(s);
            live_addrs.push_back(ea);
        end
    endtask

    task automatic lookup(logic [31:0] aa, logic [3:0] al, logic [31:0] av);
        send_request(KIND_LOOKUP, 6'($urandom), $urandom, $urandom, 16'($urandom),
                     $urandom, $urandom, 1'($urandom), aa, al, av);
    endtask

    // wait until every result is in, let the back end settle, then write
    task automatic drain_and_configure(logic v);
        req.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one random request: mostly enables and lookups aimed at live entries
    task automatic random_request();
        int          pick;
        int          idx;
        logic [31:0] base;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // small address pool so ties and key order are exercised
            base = ($urandom_range(3) == 0) ? $urandom : {24'h0, 4'h0,
                   4'($urandom_range(15))} << 4;
            enable_entry($urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(31)),
                         base,
                         ($urandom_range(3) == 0) ? $urandom : 32'hffff_ffff,
                         ($urandom_range(7) == 0) ? 16'($urandom) :
                             16'($urandom_range(15)),
                         $urandom, $urandom, 1'($urandom));
        end
        else if (pick < 50)
        begin
            if (live_slots.size() > 0 && $urandom_range(3) != 0)
            begin
                idx = $urandom_range(live_slots.size() - 1);
                send_request(KIND_DISABLE, live_slots[idx], $urandom, $urandom,
                             16'($urandom), $urandom, $urandom, 1'($urandom),
                             $urandom, 4'($urandom), $urandom);
                live_slots.delete(idx);
                live_addrs.delete(idx);
            end
            else
                send_request(KIND_DISABLE, 6'($urandom), $urandom, $urandom,
                             16'($urandom), $urandom, $urandom, 1'($urandom),
                             $urandom, 4'($urandom), $urandom);
        end
        else if (pick < 97)
        begin
            if (live_addrs.size() > 0 && $urandom_range(3) != 0)
            begin
                idx = $urandom_range(live_addrs.size() - 1);
                lookup(live_addrs[idx] + 32'($urandom_range(20)),
                       4'($urandom_range(8)),
                       ($urandom_range(1)) ? $urandom : 32'h0);
            end
            else
                lookup($urandom, 4'($urandom_range(8)), $urandom);
        end
        else
            send_request(KIND_NONE, 6'($urandom), $urandom, $urandom, 16'($urandom),
                         $urandom, $urandom, 1'($urandom), $urandom, 4'($urandom),
                         $urandom);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        steady_mode = 1'b0;
        hold_off = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_NONE;
        req.slot = '0;
        req.entry_address = '0;
        req.entry_address_mask = '0;
        req.entry_range_length = '0;
        req.entry_compare_value = '0;
        req.entry_compare_mask = '0;
        req.entry_compare_enable = 1'b0;
        req.access_address = '0;
        req.access_length = '0;
        req.access_value = '0;
        rsp.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty-table cases first
        send_request(KIND_DISABLE, 6'd5, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        lookup(32'h0, 4'd0, 32'h0);
        send_request(KIND_NONE, 6'h3f, '1, '1, '1, '1, '1, 1'b1, '1, 4'hf, '1);
        // extremes of the entry fields, value compare on and off
        enable_entry(6'd63, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, '1, '1, 1'b1);
        enable_entry(6'd0, 32'h0, 32'hffff_ffff, 16'h0, 32'h1234, 32'hff, 1'b1);
        enable_entry(6'd0, 32'h40, '1, 16'h4, '0, '0, 1'b0);   // already enabled
        enable_entry(6'd1, 32'h100, 32'hffff_ff00, 16'h10, '0, '0, 1'b0);
        enable_entry(6'd2, 32'h100, '1, 16'h8, '0, '0, 1'b0);  // equal address
        lookup(32'h0, 4'd1, 32'h34);                    // value passes
        lookup(32'h0, 4'd1, 32'h35);                    // value fails, ends search
        lookup(32'hffff_ffff, 4'd8, 32'h0);             // top of space, no wrap
        lookup(32'h105, 4'd0, 32'h0);
        lookup(32'h5000, 4'd8, '1);                     // miss
        send_request(KIND_DISABLE, 6'd40, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send_request(KIND_DISABLE, 6'd2, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        // fill to full, then one more enable is refused
        for (int i = 0; i < 13; i++)
            enable_entry(6'(10 + i), 32'(i * 32'h20), '1, 16'h1, '0, '0, 1'b0);
        enable_entry(6'd50, 32'h7, '1, 16'h1, '0, '0, 1'b0);
        lookup(32'h41, 4'd0, 32'h0);

        // random phases across both sort keys, with extremes revisited
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_and_configure(phase[0] ? 1'b0 : 1'b1);
            steady_mode = (phase == 2);
            for (int n = 0; n < 340; n++)
            begin
                random_request();
                if (phase == 1 && n == 100)
                begin
                    // sender pauses until every result is in
                    req.valid <= 1'b0;
                    @(negedge clk);
                    while (pending_count != 0)
                        @(negedge clk);
                end
            end
            if (phase == 0)
            begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    for (int n = 0; n < 10; n++)
                        random_request();
                join
            end
        end

        req.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/swtm_pkg.sv
rtl/core/swtm_if.sv
rtl/core/swtm_front.sv
rtl/core/swtm_back.sv
rtl/core/sorted_watchpoint_table_match.sv
sim/swtm_match_checker.sv
sim/sorted_watchpoint_table_match_test.sv
